// ===== src/srrw_pkg.sv =====
// Shared constants, codes and control types of the selective-repeat receive window.
`timescale 1ns / 1ps

package srrw_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned WINDOW_MAX_DEF = 32;
  localparam int unsigned SEQ_WIDTH_DEF  = 16;

  // Register field widths.
  localparam int unsigned WIN_LEN_W  = 6;
  localparam int unsigned SEQ_BITS_W = 5;
  localparam int unsigned TOTAL_W    = 20;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register reset values.
  localparam logic [WIN_LEN_W-1:0]  WIN_LEN_RST  = WIN_LEN_W'(8);
  localparam logic [SEQ_BITS_W-1:0] SEQ_BITS_RST = SEQ_BITS_W'(8);
  localparam logic [TOTAL_W-1:0]    TOTAL_RST    = TOTAL_W'(1000);

  // The delivery counter saturates at its largest value.
  localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN    = 2'd0,
    CFG_SEQ_BITS      = 2'd1,
    CFG_TOTAL_PACKETS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_ACK   = 1'b0,
    KIND_DELIV = 1'b1
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_ack;
    logic load_deliv;
  } srrw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_last;
  } srrw_status_t;

endpackage

// ===== src/srrw_ctrl.sv =====
// Controller of the receive window: accepts one item, then walks its result transfers.
`timescale 1ns / 1ps

module srrw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output srrw_pkg::srrw_cmd_t  cmd_o,
  input  srrw_pkg::srrw_status_t status_i
);
  import srrw_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_stall_q;

  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load_ack   = (state_q == S_IDLE) && in_valid_i && !in_stall_q;
    cmd_o.load_deliv = (state_q == S_BUSY) && out_valid_q && !out_stall_i &&
                       !status_i.out_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      in_stall_q  <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          in_stall_q <= 1'b0;
          if (in_valid_i && !in_stall_q) begin
            state_q     <= S_BUSY;
            out_valid_q <= 1'b1;
            in_stall_q  <= 1'b1;
          end
        end
        S_BUSY: begin
          if (out_valid_q && !out_stall_i && status_i.out_last) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_stall_q  <= 1'b0;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
          in_stall_q  <= 1'b1;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_stall_q)
    else $error("input ready while a result is pending");

  a_ack_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_ack |=> out_valid_q)
    else $error("accepted item did not raise a result");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_ack, cmd_o.load_deliv}))
    else $error("acknowledge and delivery loaded together");
`endif

endmodule

// ===== src/srrw_dp.sv =====
// Datapath of the receive window: registers, slot marks, base, counter, result register.
`timescale 1ns / 1ps

module srrw_dp #(
  parameter int unsigned WINDOW_MAX = srrw_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SEQ_WIDTH  = srrw_pkg::SEQ_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [srrw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [srrw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [SEQ_WIDTH-1:0]             seq_in_i,
  input  srrw_pkg::srrw_cmd_t              cmd_i,
  output srrw_pkg::srrw_status_t           status_o,
  output logic                             kind_o,
  output logic [SEQ_WIDTH-1:0]             seq_out_o,
  output logic                             in_window_o,
  output logic                             all_done_o,
  output logic                             last_o
);
  import srrw_pkg::*;

  localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CMP_W = SEQ_WIDTH + WIN_LEN_W;
  localparam int unsigned SB_W  = SEQ_BITS_W + 1;

  // Configuration registers.
  logic [WIN_LEN_W-1:0]  win_len_q;
  logic [SEQ_BITS_W-1:0] seq_bits_q;
  logic [TOTAL_W-1:0]    total_q;

  // Window state.
  logic [WINDOW_MAX-1:0] slot_q, slot_d;
  logic [SEQ_WIDTH-1:0]  base_q, base_d;
  logic [TOTAL_W-1:0]    count_q, count_d;

  // Result register.
  kind_e                 kind_q, kind_d;
  logic [SEQ_WIDTH-1:0]  seq_q, seq_d;
  logic                  inw_q, inw_d;
  logic                  done_q, done_d;
  logic                  last_q, last_d;

  logic [WIN_LEN_W-1:0]  w_eff;
  logic [SB_W-1:0]       bits_eff;
  logic [SEQ_WIDTH-1:0]  mask;
  logic [SEQ_WIDTH-1:0]  seq_m;
  logic [SEQ_WIDTH-1:0]  base_m;
  logic [SEQ_WIDTH-1:0]  off;
  logic                  done_now;
  logic                  hit;
  logic [WINDOW_MAX-1:0] slot_mark;
  logic [WINDOW_MAX-1:0] slot_up;
  logic [WINDOW_MAX-1:0] slot_shift;
  logic [TOTAL_W-1:0]    count_inc;

  // Effective window length and sequence space after clamping.
  always_comb begin
    if (win_len_q == '0) begin
      w_eff = WIN_LEN_W'(1);
    end else if (win_len_q > WIN_LEN_W'(WINDOW_MAX)) begin
      w_eff = WIN_LEN_W'(WINDOW_MAX);
    end else begin
      w_eff = win_len_q;
    end
    if (seq_bits_q == '0) begin
      bits_eff = SB_W'(1);
    end else if ({1'b0, seq_bits_q} > SB_W'(SEQ_WIDTH)) begin
      bits_eff = SB_W'(SEQ_WIDTH);
    end else begin
      bits_eff = {1'b0, seq_bits_q};
    end
  end

  assign mask     = ~({SEQ_WIDTH{1'b1}} << bits_eff);
  assign seq_m    = seq_in_i & mask;
  assign base_m   = base_q & mask;
  assign off      = (seq_m - base_m) & mask;
  assign done_now = (count_q >= total_q);
  assign hit      = !done_now && (CMP_W'(off) < CMP_W'(w_eff));

  // Slot marks with the arriving packet recorded.
  always_comb begin
    slot_mark = slot_q;
    if (hit) begin
      slot_mark[off[IDX_W-1:0]] = 1'b1;
    end
  end

  // One-place slide; slots at or past the window end come in empty.
  assign slot_up = slot_q >> 1;
  always_comb begin
    for (int i = 0; i < int'(WINDOW_MAX); i++) begin
      slot_shift[i] = slot_up[i] && ((i + 1) < int'(w_eff));
    end
  end

  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + TOTAL_W'(1);

  always_comb begin
    slot_d  = slot_q;
    base_d  = base_q;
    count_d = count_q;
    kind_d  = kind_q;
    seq_d   = seq_q;
    inw_d   = inw_q;
    done_d  = done_q;
    last_d  = last_q;
    priority if (cmd_i.load_ack) begin
      slot_d = slot_mark;
      kind_d = KIND_ACK;
      seq_d  = seq_m;
      inw_d  = hit;
      done_d = done_now;
      last_d = done_now || !slot_mark[0];
    end else if (cmd_i.load_deliv) begin
      slot_d  = slot_shift;
      base_d  = (base_m + SEQ_WIDTH'(1)) & mask;
      count_d = count_inc;
      kind_d  = KIND_DELIV;
      seq_d   = base_m;
      inw_d   = 1'b1;
      done_d  = (count_inc >= total_q);
      last_d  = !slot_shift[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q  <= WIN_LEN_RST;
      seq_bits_q <= SEQ_BITS_RST;
      total_q    <= TOTAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW_LEN:    win_len_q  <= cfg_data_i[WIN_LEN_W-1:0];
        CFG_SEQ_BITS:      seq_bits_q <= cfg_data_i[SEQ_BITS_W-1:0];
        CFG_TOTAL_PACKETS: total_q    <= cfg_data_i[TOTAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      base_q  <= '0;
      count_q <= '0;
    end else begin
      slot_q  <= slot_d;
      base_q  <= base_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    seq_q  <= seq_d;
    inw_q  <= inw_d;
    done_q <= done_d;
    last_q <= last_d;
  end

  assign status_o.out_last = last_q;
  assign kind_o            = kind_q;
  assign seq_out_o         = seq_q;
  assign in_window_o       = inw_q;
  assign all_done_o        = done_q;
  assign last_o            = last_q;

`ifndef SYNTHESIS
  a_deliver_marked_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_deliv |-> slot_q[0])
    else $error("delivery from an unmarked slot");

  a_done_ack_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_ack && done_now |=> last_q && !inw_q)
    else $error("acknowledge after completion not final");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q >= $past(count_q))
    else $error("delivery counter went backward");
`endif

endmodule

// ===== src/selective_repeat_receive_window.sv =====
// Top level of the selective-repeat receive window: controller, datapath and ports.
// The acknowledgement is shown in the cycle after the input transfer; each delivery
// of the in-order run is shown in the cycle after the previous result transfer.
// A new item is taken only once all results of the previous one have been transferred:
// its acknowledgement, then the run delivered (0 to 32) through the single result register.
// Reset (rst_ni, asynchronous, active low) clears marks, base and counter and loads defaults.
`timescale 1ns / 1ps

module selective_repeat_receive_window #(
  parameter int unsigned WINDOW_MAX = srrw_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SEQ_WIDTH  = srrw_pkg::SEQ_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [srrw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [srrw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input channel: one arriving sequence number per transfer.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [SEQ_WIDTH-1:0]            seq_in_i,
  // Output channel: acknowledgements and in-order deliveries.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            kind_o,
  output logic [SEQ_WIDTH-1:0]            seq_out_o,
  output logic                            in_window_o,
  output logic                            all_done_o,
  output logic                            last_o
);
  import srrw_pkg::*;

  // The controller only sequences transfers. It takes an item when idle, holds the input
  // stalled while the results of that item are offered, and asks the datapath for the
  // next delivery each time a non-final result transfer completes.
  srrw_cmd_t    cmd;
  srrw_status_t status;

  srrw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // The datapath keeps the received marks as a vector that slides one place per delivery,
  // so the head of the run is always the lowest mark. The base and the delivery counter
  // advance with each delivery, and the result register holds the payload on the port.
  srrw_dp #(
    .WINDOW_MAX (WINDOW_MAX),
    .SEQ_WIDTH  (SEQ_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .seq_in_i    (seq_in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_o      (kind_o),
    .seq_out_o   (seq_out_o),
    .in_window_o (in_window_o),
    .all_done_o  (all_done_o),
    .last_o      (last_o)
  );

endmodule

// ===== tb/srrw_checker.sv =====
// Checker that predicts and compares every result of the selective-repeat receive window.
`timescale 1ns / 1ps

module srrw_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [srrw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [srrw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [15:0]                     seq_in_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            kind_i,
  input  logic [15:0]                     seq_out_i,
  input  logic                            in_window_i,
  input  logic                            all_done_i,
  input  logic                            last_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              acks_o,
  output int                              deliveries_o,
  output logic [15:0]                     base_o,
  output logic [srrw_pkg::TOTAL_W-1:0]    delivered_o
);
  import srrw_pkg::*;

  localparam int unsigned WIN_MAX = WINDOW_MAX_DEF;
  localparam int unsigned SEQ_W   = SEQ_WIDTH_DEF;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    kind_e            kind;
    logic [SEQ_W-1:0] seq;
    logic             in_window;
    logic             all_done;
    logic             last;
  } window_result_t;

  window_result_t owed_results[$];

  logic [WIN_LEN_W-1:0]  win_len;
  logic [SEQ_BITS_W-1:0] seq_bits;
  logic [TOTAL_W-1:0]    total_packets;
  logic [WIN_MAX-1:0]    marks;
  logic [SEQ_W-1:0]      base;
  logic [TOTAL_W-1:0]    delivered;
  int                    results_seen;

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= MAX_PRINTED) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  // Appends one expected result at the tail of the queue.
  task automatic owe_result(input window_result_t r);
    owed_results.insert(owed_results.size(), r);
  endtask

  // Acknowledge one arriving number, then deliver the unbroken run from the base.
  task automatic receive_packet(input logic [SEQ_W-1:0] raw);
    int unsigned w;
    int unsigned nbits;
    int unsigned run;
    logic [SEQ_W-1:0] mask;
    logic [SEQ_W-1:0] s;
    logic [SEQ_W-1:0] b;
    logic [SEQ_W-1:0] off;
    logic [WIN_MAX-1:0] slid;
    w = (win_len == 0) ? 1 : ((win_len > WIN_MAX) ? WIN_MAX : win_len);
    nbits = (seq_bits == 0) ? 1 : ((seq_bits > SEQ_W) ? SEQ_W : seq_bits);
    mask = SEQ_W'((33'd1 << nbits) - 1);
    s = raw & mask;
    b = base & mask;
    if (delivered >= total_packets) begin
      // Reception is complete: acknowledge and leave the window alone.
      owe_result(window_result_t'{KIND_ACK, s, 1'b0, 1'b1, 1'b1});
    end else begin
      off = (s - b) & mask;
      if (off < w) begin
        marks[off] = 1'b1;
      end
      run = 0;
      while (run < w && marks[run]) begin
        run++;
      end
      owe_result(window_result_t'{KIND_ACK, s, off < w, 1'b0, run == 0});
      for (int unsigned i = 0; i < run; i++) begin
        if (delivered != COUNT_MAX) begin
          delivered++;
        end
        owe_result(window_result_t'{KIND_DELIV, (b + SEQ_W'(i)) & mask, 1'b1,
                                    delivered >= total_packets, i == run - 1});
      end
      if (run > 0) begin
        for (int unsigned i = 0; i < WIN_MAX; i++) begin
          slid[i] = (i + run < w) ? marks[i + run] : 1'b0;
        end
        marks = slid;
        base = (b + SEQ_W'(run)) & mask;
      end
    end
  endtask

  task automatic check_result();
    window_result_t want;
    results_seen++;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("result %0d (kind %0d, seq %0d) arrived with none owed",
                                results_seen, kind_i, seq_out_i));
    end else begin
      want = owed_results.pop_front();
      if (kind_i !== want.kind) begin
        report_mismatch($sformatf("result %0d: kind %0d, expected %0d",
                                  results_seen, kind_i, want.kind));
      end
      if (seq_out_i !== want.seq) begin
        report_mismatch($sformatf("result %0d: seq_out %0d, expected %0d",
                                  results_seen, seq_out_i, want.seq));
      end
      if (in_window_i !== want.in_window) begin
        report_mismatch($sformatf("result %0d: in_window %0d, expected %0d",
                                  results_seen, in_window_i, want.in_window));
      end
      if (all_done_i !== want.all_done) begin
        report_mismatch($sformatf("result %0d: all_done %0d, expected %0d",
                                  results_seen, all_done_i, want.all_done));
      end
      if (last_i !== want.last) begin
        report_mismatch($sformatf("result %0d: last %0d, expected %0d",
                                  results_seen, last_i, want.last));
      end
    end
    if (kind_i == KIND_DELIV) begin
      deliveries_o++;
    end else begin
      acks_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len       = WIN_LEN_RST;
      seq_bits      = SEQ_BITS_RST;
      total_packets = TOTAL_RST;
      marks         = '0;
      base          = '0;
      delivered     = '0;
      results_seen  = 0;
      owed_results.delete();
      fail_count_o  = 0;
      acks_o        = 0;
      deliveries_o  = 0;
    end else begin
      // Results go first: anything leaving now was owed by an earlier transfer.
      if (out_valid_i && !out_stall_i) begin
        check_result();
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WINDOW_LEN:    win_len = cfg_data_i[WIN_LEN_W-1:0];
          CFG_SEQ_BITS:      seq_bits = cfg_data_i[SEQ_BITS_W-1:0];
          CFG_TOTAL_PACKETS: total_packets = cfg_data_i[TOTAL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        receive_packet(seq_in_i);
      end
    end
    pending_o   = owed_results.size();
    base_o      = base;
    delivered_o = delivered;
  end

endmodule

// ===== tb/tb_selective_repeat_receive_window.sv =====
// Testbench top of the selective-repeat receive window: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_selective_repeat_receive_window;
  import srrw_pkg::*;

  // The run ends here even if the block hangs; a correct run needs a small fraction.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles allowed after the last owed result before the block counts as idle.
  localparam int SETTLE = 4;
  localparam int TOTAL_ALL = 20'hFFFFF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_WINDOW_LEN;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [15:0]           seq_in_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  kind_o;
  logic [15:0]           seq_out_o;
  logic                  in_window_o;
  logic                  all_done_o;
  logic                  last_o;

  int                    fail_count;
  int                    pending;
  int                    acks;
  int                    deliveries;
  logic [15:0]           base_now;
  logic [TOTAL_W-1:0]    delivered_now;

  // Window and sequence space the stimulus aims at; they follow every register write.
  int unsigned win_eff = 8;
  logic [15:0] space_mask = 16'h00FF;

  int burst_left = 0;
  int items_sent = 0;
  int n_settings = 1;
  int cycle_count = 0;

  // Receiver state: a requested hold-off and the current stall pattern.
  int hold_len = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stretch_left = 0;

  always #2 clk_i = ~clk_i;

  selective_repeat_receive_window DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .seq_in_i    (seq_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .seq_out_o   (seq_out_o),
    .in_window_o (in_window_o),
    .all_done_o  (all_done_o),
    .last_o      (last_o)
  );

  srrw_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .seq_in_i     (seq_in_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_i       (kind_o),
    .seq_out_i    (seq_out_o),
    .in_window_i  (in_window_o),
    .all_done_i   (all_done_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .acks_o       (acks),
    .deliveries_o (deliveries),
    .base_o       (base_now),
    .delivered_o  (delivered_now)
  );

  // The receiver picks a new stall pattern for each random stretch: open stretches,
  // light and heavy random stalls, and a fixed two-in-five pattern. A hold-off request
  // from the stimulus overrides all of these and is counted down here.
  always @(posedge clk_i) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stretch_left = $urandom_range(8, 60);
      end
      stretch_left--;
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 1) == 0);
        2:       out_stall_i <= ($urandom_range(0, 4) == 0);
        default: out_stall_i <= ((stretch_left % 5) < 2);
      endcase
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed.", cycle_count, pending);
      $display("selective_repeat_receive_window: mismatch");
      $finish;
    end
  end

  // Offers one sequence number and returns at the edge of its transfer. The sender
  // works in bursts; between bursts valid drops for a random gap, sometimes none.
  task automatic send_seq(input logic [15:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    seq_in_i   <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Stops offering and waits until every owed result has come out. The count is
  // read at the falling edge so that it never races the checker's update.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive edges once the block is idle.
  task automatic next_setting(input int wl, input int sb, input int tp);
    int wl_f;
    int sb_f;
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WINDOW_LEN;
    cfg_data_i <= CFG_DATA_W'(wl);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SEQ_BITS;
    cfg_data_i <= CFG_DATA_W'(sb);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TOTAL_PACKETS;
    cfg_data_i <= CFG_DATA_W'(tp);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    // Zero means one and large values saturate, in both registers.
    wl_f = wl & 63;
    sb_f = sb & 31;
    win_eff = (wl_f == 0) ? 1 : ((wl_f > 32) ? 32 : wl_f);
    sb_f = (sb_f == 0) ? 1 : ((sb_f > 16) ? 16 : sb_f);
    space_mask = 16'((32'd1 << sb_f) - 1);
    n_settings++;
  endtask

  // Sends well-formed windows: each one covers the numbers from the current base,
  // in order, shuffled, lightly swapped, or with the base number held back to the
  // end so that a single arrival releases the whole window. Noise, duplicates and
  // numbers with stray high bits are mixed in.
  task automatic run_phase(input int n_items);
    logic [15:0] order [32];
    logic [15:0] tx;
    logic [15:0] tmp;
    logic [15:0] pick;
    int sent;
    int len;
    int k;
    int j;
    int r;
    int mode;
    sent = 0;
    tx = base_now & space_mask;
    while (sent < n_items) begin
      len = (win_eff < int'(space_mask) + 1) ? win_eff : int'(space_mask) + 1;
      mode = $urandom_range(0, 3);
      for (k = 0; k < len; k++) begin
        if (mode == 3) begin
          order[k] = (tx + 16'((k + 1) % len)) & space_mask;
        end else begin
          order[k] = (tx + 16'(k)) & space_mask;
        end
      end
      if (mode == 1) begin
        for (k = len - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
      end else if (mode == 2 && len > 1) begin
        repeat ($urandom_range(1, 3)) begin
          k = $urandom_range(0, len - 1);
          j = $urandom_range(0, len - 1);
          tmp = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
      end
      for (k = 0; k < len && sent < n_items; k++) begin
        r = $urandom_range(0, 9);
        pick = order[k];
        if (r == 0) begin
          send_seq(16'($urandom_range(0, 65535)));
          sent++;
        end else if (r == 1) begin
          send_seq(order[$urandom_range(0, k)]);
          sent++;
        end else if (r == 2) begin
          pick = pick | (16'($urandom_range(0, 65535)) & ~space_mask);
        end
        send_seq(pick);
        sent++;
      end
      tx = (tx + 16'(len)) & space_mask;
    end
  endtask

  initial begin
    int k;
    int b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: window of 8 in a space of 256. In-order, out-of-order with a gap
    // that one arrival fills, the last slot of the window, the first slot past it,
    // an old duplicate behind the base, and numbers wider than the space.
    send_seq(16'd0);
    send_seq(16'd2);
    send_seq(16'd3);
    send_seq(16'd1);
    send_seq(16'd11);
    send_seq(16'd12);
    send_seq(16'd3);
    send_seq(16'hFFFF);
    send_seq(16'h0104);
    for (k = 5; k <= 10; k++) begin
      send_seq(16'(k));
    end

    // Shrinking the window: marks just past the new length are ignored, and the
    // next slide clears them, so they are not delivered once the window grows back.
    next_setting(16, 8, TOTAL_ALL);
    b0 = base_now;
    send_seq(16'(b0 + 4));
    send_seq(16'(b0 + 5));
    next_setting(4, 8, TOTAL_ALL);
    send_seq(16'(b0 + 1));
    send_seq(16'(b0));
    next_setting(16, 8, TOTAL_ALL);
    send_seq(16'(b0 + 3));
    send_seq(16'(b0 + 2));

    // Both registers above their limits saturate: a window of 32 in 16-bit numbers.
    next_setting(63, 31, TOTAL_ALL);
    run_phase(40);

    // Both registers at zero act as one: a single slot in a space of two.
    next_setting(0, 0, TOTAL_ALL);
    run_phase(15);

    // A tiny space, so the base wraps around many times.
    next_setting(4, 3, TOTAL_ALL);
    run_phase(30);

    // The receiver holds off long enough for the block to fill and stall its input
    // while the sender keeps offering whole windows of 32.
    next_setting(32, 6, TOTAL_ALL);
    hold_len = 150;
    run_phase(40);

    // Completion a few deliveries into the phase; later arrivals are only
    // acknowledged, outside the window and with the done flag up.
    next_setting(8, 8, delivered_now + 6);
    run_phase(15);

    // A total of zero means reception is complete at once.
    next_setting(5, 4, 0);
    run_phase(8);

    // Smallest window in the widest space, then a window far larger than the space.
    next_setting(1, 16, TOTAL_ALL);
    run_phase(15);
    next_setting(32, 1, TOTAL_ALL);
    run_phase(12);

    repeat (2) begin
      next_setting($urandom_range(1, 32), $urandom_range(1, 16), TOTAL_ALL);
      run_phase(20);
    end

    // Drain, then give the block time to show any result it should not produce.
    wait_idle();
    repeat (40) @(posedge clk_i);

    $display("Run covered %0d arrivals under %0d register settings: %0d acknowledgements,",
             items_sent, n_settings, acks);
    $display("%0d in-order deliveries, window wraparound, shrink, completion and hold-off.",
             deliveries);
    if (fail_count == 0) begin
      $display("selective_repeat_receive_window: match");
    end else begin
      $display("selective_repeat_receive_window: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/srrw_pkg.sv
src/srrw_ctrl.sv
src/srrw_dp.sv
src/selective_repeat_receive_window.sv
tb/srrw_checker.sv
tb/tb_selective_repeat_receive_window.sv
